// ===== rtl/fppa_pkg.sv =====
// Shared types and character constants for the FTP PORT/PASV address parser.
package fppa_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_NOMATCH = 3'd1,
    PH_SKIP    = 3'd2,
    PH_SEP     = 3'd3,
    PH_NUM     = 3'd4,
    PH_OK      = 3'd5,
    PH_FAIL    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PORT    = 2'd0,
    KIND_PASV    = 2'd1,
    KIND_NEITHER = 2'd2
  } kind_t;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] PORT_LEN = 3'd4;
  localparam logic [2:0] PASV_LEN = 3'd3;
  localparam logic [2:0] LAST_NUM = 3'd5;

  localparam logic [15:0] CONTROL_PORT_RESET = 16'd21;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  byte_pos;
    logic [2:0]  num_idx;
    logic [31:0] acc;
    logic [31:0] addr;
    logic [15:0] port;
    kind_t       kind;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:    PH_PREFIX,
    byte_pos: 3'd0,
    num_idx:  3'd0,
    acc:      32'd0,
    addr:     32'd0,
    port:     16'd0,
    kind:     KIND_NEITHER
  };

  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic        ok;
    logic [31:0] addr;
    logic [15:0] port;
  } step_result_t;

endpackage

// ===== rtl/fppa_step.sv =====
// Per-byte parser step: next parse state and the packet result on the last byte.
module fppa_step (
  input  fppa_pkg::parse_state_t state,
  input  logic [7:0]             payload_byte,
  input  logic [15:0]            dest_port,
  input  logic                   last_byte,
  input  logic [15:0]            control_port,
  output fppa_pkg::parse_state_t state_next,
  output fppa_pkg::step_result_t result
);
  import fppa_pkg::*;

  function automatic parse_state_t commit(input parse_state_t s);
    parse_state_t r;
    r = s;
    case (s.num_idx)
      3'd0:    r.addr = {s.acc[7:0], 24'd0};
      3'd1:    r.addr = s.addr | {s.acc[15:0], 16'd0};
      3'd2:    r.addr = s.addr | {s.acc[23:0], 8'd0};
      3'd3:    r.addr = s.addr | s.acc;
      3'd4:    r.port = {s.acc[7:0], 8'd0};
      default: r.port = s.port | s.acc[15:0];
    endcase
    return r;
  endfunction

  parse_state_t s1;
  parse_state_t s2;
  kind_t        cur_kind;
  logic [2:0]   prefix_len;
  logic [7:0]   want;
  logic [2:0]   pos_inc;
  logic         is_digit;
  logic         is_space;
  logic [31:0]  digit_val;
  kind_t        out_kind;

  always_comb begin
    is_digit  = payload_byte inside {[8'h30:8'h39]};
    is_space  = (payload_byte == 8'h20) || (payload_byte inside {[8'h09:8'h0D]});
    digit_val = {28'd0, payload_byte[3:0]};

    cur_kind   = (state.byte_pos == 3'd0) ?
                 ((dest_port == control_port) ? KIND_PORT : KIND_PASV) : state.kind;
    prefix_len = (cur_kind == KIND_PORT) ? PORT_LEN : PASV_LEN;
    if (cur_kind == KIND_PORT) begin
      case (state.byte_pos[1:0])
        2'd0:    want = CH_P;
        2'd1:    want = CH_O;
        2'd2:    want = CH_R;
        default: want = CH_T;
      endcase
    end else begin
      // The reply prefix repeats every three positions.
      want = (state.byte_pos == 3'd2 || state.byte_pos == 3'd5) ? CH_7 : CH_2;
    end
    pos_inc = state.byte_pos + 3'd1;

    s1 = state;
    case (state.phase)
      PH_PREFIX: begin
        s1.kind = cur_kind;
        if (payload_byte != want) begin
          s1.phase = PH_NOMATCH;
          s1.kind  = KIND_NEITHER;
        end else begin
          s1.byte_pos = pos_inc;
          if (pos_inc >= prefix_len) s1.phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (is_digit) begin
          s1.acc   = digit_val;
          s1.phase = PH_NUM;
        end else if (payload_byte == CH_NUL) begin
          s1.phase = PH_FAIL;
        end
      end
      PH_SEP: begin
        if (is_digit) begin
          s1.acc   = digit_val;
          s1.phase = PH_NUM;
        end else if (!is_space) begin
          s1.phase = PH_FAIL;
        end
      end
      PH_NUM: begin
        if (is_digit) begin
          s1.acc = {state.acc[28:0], 3'd0} + {state.acc[30:0], 1'b0} + digit_val;
        end else if (state.num_idx >= LAST_NUM) begin
          s1       = commit(state);
          s1.phase = PH_OK;
        end else if (payload_byte == CH_COMMA) begin
          s1         = commit(state);
          s1.num_idx = state.num_idx + 3'd1;
          s1.phase   = PH_SEP;
        end else begin
          s1.phase = PH_FAIL;
        end
      end
      default: ;
    endcase

    // The sixth number may run up to the end of the packet.
    s2 = s1;
    if (s1.phase == PH_NUM && s1.num_idx >= LAST_NUM) begin
      s2       = commit(s1);
      s2.phase = PH_OK;
    end

    out_kind = (s2.phase == PH_PREFIX || s2.phase == PH_NOMATCH) ? KIND_NEITHER : s2.kind;

    result.emit = last_byte;
    result.kind = out_kind;
    result.ok   = (out_kind != KIND_NEITHER) && (s2.phase == PH_OK);
    result.addr = result.ok ? s2.addr : 32'd0;
    result.port = result.ok ? s2.port : 16'd0;

    state_next = last_byte ? STATE_RESET : s1;
  end

endmodule

// ===== rtl/ftp_port_pasv_address_parser_core.sv =====
// Top level of the FTP PORT/PASV address parser: handshakes, state and result registers.
//
// Payload bytes of a packet enter on the s_axis channel, one per request, with the
// packet's destination port beside each byte and tlast on the final byte. If the
// destination port equals control_port the payload must start with "PORT", otherwise
// with "227"; six comma-separated decimal numbers follow and give the address and port.
// One result leaves on m_axis for each packet, taken on its last byte; other bytes
// give no result.
// Throughput is one byte per cycle unless a stalled result blocks the step: a byte sits
// in the input register while the step logic updates the parse state, and the result
// lands in the output register. m_axis_tvalid rises once the last byte has passed the
// input register and the step into the output register.
// When the receiver stalls with a result waiting, a byte already held in the input
// register waits and s_axis_tready drops at once; with the input register empty, one
// more byte is taken before s_axis_tready drops.
// The user must write control_port (cfg_valid/cfg_data) only while no packet is in
// flight; the block does not enforce this. Reset (rst, synchronous) empties both
// registers, sets control_port to 21 and returns the parser to the start of a packet.
module ftp_port_pasv_address_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,        // control_port
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // [7:0] payload_byte, [23:8] dest_port
  input  logic        s_axis_tlast,    // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // [31:0] ipv4_address, [47:32] tcp_port
  output logic [2:0]  m_axis_tuser     // [1:0] message_kind, [2] parse_ok
);
  import fppa_pkg::*;

  logic [15:0]  control_port;
  logic         in_valid;
  logic [7:0]   in_byte;
  logic [15:0]  in_dport;
  logic         in_last;
  parse_state_t state;
  parse_state_t state_next;
  step_result_t result;
  logic         step_fire;
  logic         out_valid;
  kind_t        out_kind;
  logic         out_ok;
  logic [31:0]  out_addr;
  logic [15:0]  out_port;

  assign cfg_ready     = 1'b1;
  assign step_fire     = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_port <= CONTROL_PORT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      control_port <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata[7:0];
      in_dport <= s_axis_tdata[23:8];
      in_last  <= s_axis_tlast;
    end
  end

  fppa_step u_step (
    .state        (state),
    .payload_byte (in_byte),
    .dest_port    (in_dport),
    .last_byte    (in_last),
    .control_port (control_port),
    .state_next   (state_next),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire && result.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && result.emit) begin
      out_kind <= result.kind;
      out_ok   <= result.ok;
      out_addr <= result.addr;
      out_port <= result.port;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_port, out_addr};
  assign m_axis_tuser  = {out_ok, out_kind};

`ifndef NO_ASSERTIONS
  a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    (step_fire && in_last) |=> (state.phase == PH_PREFIX && state.byte_pos == 3'd0
                                && state.num_idx == 3'd0))
    else $error("parse state not cleared after last byte");

  a_ok_has_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ok) |-> (out_kind != KIND_NEITHER))
    else $error("successful parse reported with kind neither");

  a_num_idx_range: assert property (@(posedge clk) disable iff (rst)
    state.num_idx <= LAST_NUM)
    else $error("number index past the sixth number");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step_fire && in_last))
    else $error("result appeared without a last byte");
`endif

endmodule
